// ===== hdl/trapezoid_motion_profile_macros.svh =====
// Assertion macros for the trapezoid motion profile block.
`ifndef TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`ifndef SYNTHESIS
`define TMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TMP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/tmp_pkg.sv =====
package tmp_pkg;

    localparam int PosWidth  = 32;
    localparam int TickWidth = 32;
    localparam int VWidth    = 31;
    localparam int AWidth    = 48;
    // Width of the wide intermediate terms, capped at 2^60.
    localparam int TermWidth = 64;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_ACCEL    = 3'd1;
    localparam logic [2:0] PH_CRUISE   = 3'd2;
    localparam logic [2:0] PH_DECEL    = 3'd3;
    localparam logic [2:0] PH_SHORT    = 3'd4;
    localparam logic [2:0] PH_FINISHED = 3'd5;
    localparam logic [2:0] PH_UNSUP    = 3'd6;

    localparam logic [0:0] CFG_VEL = 1'b0;
    localparam logic [0:0] CFG_ACC = 1'b1;

    // Datapath operations requested by the controller.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LATCH   = 4'd1;
    localparam logic [3:0] OP_DIV_ZA  = 4'd2;
    localparam logic [3:0] OP_SQ      = 4'd3;
    localparam logic [3:0] OP_DIV_SA  = 4'd4;
    localparam logic [3:0] OP_DIV_ZC  = 4'd5;
    localparam logic [3:0] OP_FINISH  = 4'd6;
    localparam logic [3:0] OP_TICK1   = 4'd7;
    localparam logic [3:0] OP_TICK2   = 4'd8;
    localparam logic [3:0] OP_TICK3   = 4'd9;
    localparam logic [3:0] OP_TICK4   = 4'd10;
    localparam logic [3:0] OP_MAC_LH  = 4'd11;
    localparam logic [3:0] OP_MAC_HL  = 4'd12;
    localparam logic [3:0] OP_MAC_HH  = 4'd13;

    typedef struct packed {
        logic                       cmd;
        logic signed [PosWidth-1:0] start_pos;
        logic signed [PosWidth-1:0] end_pos;
    } t_in_item;

    typedef struct packed {
        logic signed [PosWidth-1:0] setpoint;
        logic                       move_done;
        logic [2:0]                 phase;
    } t_out_item;

    typedef struct packed {
        logic [3:0] op;
        logic       div_start;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } t_dp_status;

endpackage

// ===== hdl/tmp_divider.sv =====
// Restoring divider, one quotient bit per cycle, 64 by 64 bits.
module tmp_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);

    logic [63:0] r_quo, n_quo;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, r_done;
    logic [64:0] w_trial;
    logic [64:0] w_shift;

    // One step: shift in the next numerator bit and try the subtract.
    always_comb begin
        w_shift = {r_rem[63:0], r_quo[63]};
        w_trial = w_shift - {1'b0, r_den};
        n_quo   = {r_quo[62:0], ~w_trial[64]};
        n_rem   = w_trial[64] ? w_shift : w_trial;
        n_cnt   = r_cnt - 7'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= n_cnt;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[63:0];

endmodule

// ===== hdl/tmp_datapath.sv =====
// Move set-up and setpoint arithmetic for one axis.
module tmp_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tmp_pkg::t_dp_cmd      i_cmd,
    input  tmp_pkg::t_in_item     i_item,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    output tmp_pkg::t_dp_status   o_status,
    output tmp_pkg::t_out_item    o_result
);

    localparam logic [63:0] Cap     = 64'h1000_0000_0000_0000;
    localparam logic [63:0] TickMax = {{(64-tmp_pkg::TickWidth){1'b0}},
                                       {tmp_pkg::TickWidth{1'b1}}};
    localparam logic signed [65:0] PosHi = (66'sd1 <<< (tmp_pkg::PosWidth - 1)) - 66'sd1;
    localparam logic signed [65:0] PosLo = -PosHi - 66'sd1;

    logic [tmp_pkg::VWidth-1:0]    r_vel;
    logic [tmp_pkg::AWidth-1:0]    r_acc;
    logic [2:0]                    r_phase;
    logic [tmp_pkg::TickWidth-1:0] r_tick;
    logic signed [63:0]            r_pos, r_base, r_start, r_end;
    logic [tmp_pkg::TickWidth-1:0] r_za, r_zc;
    logic                          r_done;
    logic [63:0]                   r_delta, r_tsacc, r_h, r_vt;
    logic [63:0]                   r_t2;
    logic [111:0]                  r_p;
    logic [63:0]                   r_div_num, r_div_den;
    logic                          r_div_go;

    logic        w_busy, w_done;
    logic [63:0] w_quo, w_rem;
    logic [63:0] w_v64, w_a64;
    logic signed [65:0] w_sum;
    logic signed [63:0] w_cl;
    logic [tmp_pkg::TickWidth-1:0] w_t1;

    tmp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    assign w_v64 = {33'd0, r_vel};
    assign w_a64 = {16'd0, r_acc};
    assign w_t1  = r_tick + 1'b1;

    // Clamp to the signed position range.
    function automatic logic signed [63:0] clampf(input logic signed [65:0] x);
        if (x > PosHi) clampf = PosHi[63:0];
        else if (x < PosLo) clampf = PosLo[63:0];
        else clampf = x[63:0];
    endfunction

    // Select the sum that sets the next setpoint.
    always_comb begin
        w_sum = '0;
        unique case (r_phase)
            tmp_pkg::PH_ACCEL:  w_sum = {{2{r_start[63]}}, r_start} + {2'b0, r_h};
            tmp_pkg::PH_CRUISE: w_sum = {{2{r_pos[63]}}, r_pos} + {2'b0, w_v64};
            tmp_pkg::PH_DECEL:  w_sum = {{2{r_base[63]}}, r_base} + {2'b0, r_vt}
                                        - {2'b0, r_h};
            tmp_pkg::PH_SHORT:  w_sum = {{2{r_start[63]}}, r_start}
                                        + {4'b0, r_vt[63:2]};
            default:            w_sum = {{2{r_pos[63]}}, r_pos};
        endcase
        w_cl = clampf(w_sum);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel <= tmp_pkg::VWidth'(65536);
            r_acc <= tmp_pkg::AWidth'(64'h1_0000_0000);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tmp_pkg::CFG_VEL) r_vel <= i_cfg_data[tmp_pkg::VWidth-1:0];
            else r_acc <= i_cfg_data[tmp_pkg::AWidth-1:0];
        end
    end

    // Operation sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= tmp_pkg::PH_IDLE;
            r_tick   <= '0;
            r_pos    <= '0;
            r_base   <= '0;
            r_start  <= '0;
            r_end    <= '0;
            r_za     <= '0;
            r_zc     <= '0;
            r_done   <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= i_cmd.div_start;
            unique case (i_cmd.op)
                tmp_pkg::OP_LATCH: begin
                    r_start   <= 64'(i_item.start_pos);
                    r_end     <= 64'(i_item.end_pos);
                    r_delta   <= 64'(64'(i_item.end_pos) - 64'(i_item.start_pos));
                    r_tick    <= '0;
                    r_done    <= 1'b0;
                    r_div_num <= w_v64 << 16;
                    r_div_den <= w_a64;
                end
                tmp_pkg::OP_DIV_ZA: begin
                    if (r_acc == '0 || w_quo > TickMax) r_za <= '1;
                    else if (w_quo == '0) r_za <= tmp_pkg::TickWidth'(1);
                    else r_za <= w_quo[tmp_pkg::TickWidth-1:0];
                    r_div_num <= w_v64 * w_v64;
                end
                tmp_pkg::OP_SQ: begin
                    // Integer part of v*v/a; the remainder is divided next.
                    if (r_acc == '0 || w_quo >= 64'h1000_0000_0000) r_tsacc <= Cap;
                    else r_tsacc <= w_quo << 16;
                    r_div_num <= w_rem << 16;
                end
                tmp_pkg::OP_DIV_SA: begin
                    if (r_tsacc != Cap) begin
                        r_tsacc <= (r_tsacc + w_quo > Cap) ? Cap : r_tsacc + w_quo;
                    end
                end
                tmp_pkg::OP_DIV_ZC: begin
                    r_div_den <= w_v64;
                    if (r_delta[63] || r_delta == '0) begin
                        r_phase <= tmp_pkg::PH_UNSUP;
                    end else if (r_delta > r_tsacc) begin
                        r_phase   <= tmp_pkg::PH_ACCEL;
                        r_div_num <= r_delta - r_tsacc;
                    end else begin
                        r_phase   <= tmp_pkg::PH_SHORT;
                        r_div_num <= r_delta << 2;
                    end
                end
                tmp_pkg::OP_FINISH: begin
                    if (r_phase == tmp_pkg::PH_ACCEL) begin
                        r_zc <= (w_quo > TickMax - 1) ? TickMax[tmp_pkg::TickWidth-1:0] - 1'b1
                                                      : w_quo[tmp_pkg::TickWidth-1:0];
                    end else if (r_phase == tmp_pkg::PH_SHORT) begin
                        r_zc <= (w_quo > TickMax) ? '1 : w_quo[tmp_pkg::TickWidth-1:0];
                    end
                end
                tmp_pkg::OP_TICK1: begin
                    r_t2 <= 64'(r_tick) * 64'(r_tick);
                    r_vt <= w_v64 * 64'(r_tick);
                end
                // A * t * t is built from four partial products, one per cycle.
                tmp_pkg::OP_TICK2: begin
                    r_p <= 112'(64'(r_acc[31:0]) * 64'(r_t2[31:0]));
                    if (r_vt > Cap && r_phase == tmp_pkg::PH_DECEL) r_vt <= Cap;
                end
                tmp_pkg::OP_MAC_LH: begin
                    r_p <= r_p + (112'(64'(r_acc[31:0]) * 64'(r_t2[63:32])) << 32);
                end
                tmp_pkg::OP_MAC_HL: begin
                    r_p <= r_p + (112'(64'(r_acc[47:32]) * 64'(r_t2[31:0])) << 32);
                end
                tmp_pkg::OP_MAC_HH: begin
                    r_p <= r_p + (112'(64'(r_acc[47:32]) * 64'(r_t2[63:32])) << 64);
                end
                tmp_pkg::OP_TICK3: begin
                    r_h <= (r_p[111:77] != '0) ? Cap : {4'd0, r_p[76:17]};
                end
                tmp_pkg::OP_TICK4: begin
                    // The last decel tick snaps to the end position.
                    r_pos <= (r_phase == tmp_pkg::PH_DECEL && r_tick == r_za) ? r_end : w_cl;
                    unique case (r_phase)
                        tmp_pkg::PH_ACCEL: begin
                            if (w_t1 == r_za) begin
                                r_phase <= tmp_pkg::PH_CRUISE;
                                r_tick  <= tmp_pkg::TickWidth'(1);
                                r_base  <= w_cl;
                            end else r_tick <= w_t1;
                        end
                        tmp_pkg::PH_CRUISE: begin
                            if (33'(r_tick) == 33'(r_zc) + 33'd1) begin
                                r_phase <= tmp_pkg::PH_DECEL;
                                r_tick  <= tmp_pkg::TickWidth'(1);
                                r_base  <= w_cl;
                            end else r_tick <= w_t1;
                        end
                        tmp_pkg::PH_DECEL: begin
                            if (r_tick == r_za) begin
                                r_done  <= 1'b1;
                                r_phase <= tmp_pkg::PH_FINISHED;
                                r_tick  <= tmp_pkg::TickWidth'(1);
                            end else r_tick <= w_t1;
                        end
                        tmp_pkg::PH_SHORT: begin
                            if (r_tick == r_zc) begin
                                r_phase <= tmp_pkg::PH_FINISHED;
                                r_tick  <= tmp_pkg::TickWidth'(1);
                            end else r_tick <= w_t1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_status.div_busy   = w_busy;
    assign o_status.div_done   = w_done;
    assign o_result.setpoint   = r_pos[tmp_pkg::PosWidth-1:0];
    assign o_result.move_done  = r_done;
    assign o_result.phase      = r_phase;

endmodule

// ===== hdl/tmp_controller.sv =====
// Sequencer: steps the datapath through set-up or one tick per item.
module tmp_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_cmd,
    input  tmp_pkg::t_dp_status i_status,
    output tmp_pkg::t_dp_cmd    o_cmd,
    output logic                o_valid,
    input  logic                i_out_ready,
    output logic                o_cmd_bit
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ZA    = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_SA    = 4'd3;
    localparam logic [3:0] S_CLS   = 4'd4;
    localparam logic [3:0] S_ZC    = 4'd5;
    localparam logic [3:0] S_T1    = 4'd6;
    localparam logic [3:0] S_T2    = 4'd7;
    localparam logic [3:0] S_T3    = 4'd8;
    localparam logic [3:0] S_T4    = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_WAIT  = 4'd11;
    localparam logic [3:0] S_MLH   = 4'd12;
    localparam logic [3:0] S_MHL   = 4'd13;
    localparam logic [3:0] S_MHH   = 4'd14;

    logic [3:0] r_state, n_state, r_after, n_after;
    logic       r_valid, n_valid;
    logic       w_acc;

    assign w_acc = i_valid && o_ready;
    // A new item enters once the previous result has gone or is leaving.
    assign o_ready = (r_state == S_IDLE) && (!r_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_valid = r_valid && !i_out_ready;
        o_cmd   = '{op: tmp_pkg::OP_NONE, div_start: 1'b0};
        unique case (r_state)
            S_IDLE: if (w_acc) begin
                if (!i_cmd) begin
                    o_cmd   = '{op: tmp_pkg::OP_LATCH, div_start: 1'b1};
                    n_state = S_WAIT;
                    n_after = S_ZA;
                end else begin
                    o_cmd   = '{op: tmp_pkg::OP_TICK1, div_start: 1'b0};
                    n_state = S_T2;
                end
            end
            S_WAIT: if (i_status.div_done) n_state = r_after;
            S_ZA: begin
                o_cmd   = '{op: tmp_pkg::OP_DIV_ZA, div_start: 1'b1};
                n_state = S_WAIT;
                n_after = S_SQ;
            end
            S_SQ: begin
                o_cmd   = '{op: tmp_pkg::OP_SQ, div_start: 1'b1};
                n_state = S_WAIT;
                n_after = S_SA;
            end
            S_SA: begin
                o_cmd   = '{op: tmp_pkg::OP_DIV_SA, div_start: 1'b0};
                n_state = S_CLS;
            end
            S_CLS: begin
                o_cmd   = '{op: tmp_pkg::OP_DIV_ZC, div_start: 1'b1};
                n_state = S_WAIT;
                n_after = S_ZC;
            end
            S_ZC: begin
                o_cmd   = '{op: tmp_pkg::OP_FINISH, div_start: 1'b0};
                n_state = S_OUT;
            end
            S_T1: n_state = S_T2;
            S_T2: begin
                o_cmd   = '{op: tmp_pkg::OP_TICK2, div_start: 1'b0};
                n_state = S_MLH;
            end
            S_MLH: begin
                o_cmd   = '{op: tmp_pkg::OP_MAC_LH, div_start: 1'b0};
                n_state = S_MHL;
            end
            S_MHL: begin
                o_cmd   = '{op: tmp_pkg::OP_MAC_HL, div_start: 1'b0};
                n_state = S_MHH;
            end
            S_MHH: begin
                o_cmd   = '{op: tmp_pkg::OP_MAC_HH, div_start: 1'b0};
                n_state = S_T3;
            end
            S_T3: begin
                o_cmd   = '{op: tmp_pkg::OP_TICK3, div_start: 1'b0};
                n_state = S_T4;
            end
            S_T4: begin
                o_cmd   = '{op: tmp_pkg::OP_TICK4, div_start: 1'b0};
                n_state = S_OUT;
            end
            S_OUT: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_valid <= n_valid;
        end
    end

    assign o_valid   = r_valid;
    assign o_cmd_bit = i_status.div_busy;

endmodule

// ===== hdl/trapezoid_motion_profile.sv =====
// Trapezoidal setpoint generator for one axis.
// Input channel (i_in_valid/o_in_ready, i_in_item): cmd 0 starts a move from
// start_pos to end_pos, cmd 1 advances one sample tick.
// Output channel (o_out_valid/i_out_ready, o_out_item): one result item per
// input item with setpoint, move_done and phase.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data):
// index 0 is velocity_per_tick, index 1 is accel_per_tick_sq; writes are
// always taken and must come while the block is idle.
// A tick item's result is offered once the item has passed through the states
// S_T2, S_MLH, S_MHL, S_MHH, S_T3, S_T4 and S_OUT (A*t*t is built from four
// partial products); a move item's result is offered once four 64-step passes
// of the shared bit-serial divider are through.
// One item is in work at a time; the result waits in an output register
// while the receiver stalls, and the next item is taken in the cycle it goes.
// Reset clears the phase to idle, the position to zero and restores the
// configuration registers to their defaults.
`include "trapezoid_motion_profile_macros.svh"
module trapezoid_motion_profile (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tmp_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tmp_pkg::t_out_item   o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [0:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    tmp_pkg::t_dp_cmd    w_cmd;
    tmp_pkg::t_dp_status w_status;
    logic                w_busy;

    tmp_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_cmd       (i_in_item.cmd),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_valid     (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd_bit   (w_busy)
    );

    tmp_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_idx  (i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_status   (w_status),
        .o_result   (o_out_item)
    );

    assign o_cfg_ready = 1'b1;

    // The divider is never running while an item can be accepted.
    `TMP_ASSERT_IMPL(a_idle_div, i_clk, i_rst_n, o_in_ready, !w_busy)
    // A result that reports move_done is always in the finished phase.
    `TMP_ASSERT_IMPL(a_done, i_clk, i_rst_n,
        o_out_valid && o_out_item.move_done,
        o_out_item.phase == tmp_pkg::PH_FINISHED)
    // After an accepted item no result is offered at once.
    `TMP_ASSERT_NEXT(a_lat, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_out_valid)

endmodule
